>>> src/indexed_list_insert_delete_defines.svh
// ----------------------------------------------------------------------------
// Indexed list store assertion macros
// Shared property wrappers for the indexed list store checks.
// ----------------------------------------------------------------------------
`ifndef INDEXED_LIST_INSERT_DELETE_DEFINES_SVH
`define INDEXED_LIST_INSERT_DELETE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define ILI_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define ILI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/ili_pkg.sv
// ----------------------------------------------------------------------------
// Indexed list store package
// Transaction types, request codes, cell commands and controller states.
// ----------------------------------------------------------------------------
package ili_pkg;

    // Request codes carried in req_type
    localparam logic [2:0] REQ_READ       = 3'd0;
    localparam logic [2:0] REQ_INS_HEAD   = 3'd1;
    localparam logic [2:0] REQ_INS_TAIL   = 3'd2;
    localparam logic [2:0] REQ_INS_AT     = 3'd3;
    localparam logic [2:0] REQ_DELETE     = 3'd4;

    // Number of cell taps merged per gather group
    localparam int GRP = 8;

    // Input transaction
    typedef struct packed {
        logic [2:0]         req_type;
        logic [6:0]         index;
        logic signed [31:0] value;
    } t_req;

    // Output transaction
    typedef struct packed {
        logic signed [31:0] read_value;
        logic               found;
        logic               accepted;
        logic [6:0]         count;
    } t_rsp;

    // Command broadcast to every cell of the row
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_READ,
        CELL_INSERT,
        CELL_DELETE
    } t_cell_op;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_GATHER,
        ST_MERGE
    } t_state;

endpackage

>>> src/ili_cell.sv
// ----------------------------------------------------------------------------
// Indexed list store cell
// One storage slot of the row: holds, loads, or takes a neighbor's word.
// ----------------------------------------------------------------------------
module ili_cell #(
    parameter int DATA_WIDTH = 32,
    parameter int CMP_W      = 7
) (
    input  logic                      i_clk,
    input  ili_pkg::t_cell_op         i_op,
    input  logic [CMP_W-1:0]          i_pos,
    input  logic [CMP_W-1:0]          i_idx,
    input  logic [DATA_WIDTH-1:0]     i_wdata,
    input  logic [DATA_WIDTH-1:0]     i_left,
    input  logic [DATA_WIDTH-1:0]     i_right,
    output logic [DATA_WIDTH-1:0]     o_data,
    output logic [DATA_WIDTH-1:0]     o_tap
);
    import ili_pkg::*;

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;
    logic [DATA_WIDTH-1:0] r_tap;
    logic [DATA_WIDTH-1:0] n_tap;

    // Pick this slot's next word from its own position against the target
    always_comb begin
        n_data = r_data;
        n_tap  = '0;
        case (i_op)
            CELL_INSERT: begin
                if (i_pos > i_idx) begin
                    n_data = i_left;
                end else if (i_pos == i_idx) begin
                    n_data = i_wdata;
                end
            end
            CELL_DELETE: begin
                if (i_pos >= i_idx) begin
                    n_data = i_right;
                end
            end
            CELL_READ: begin
                if (i_pos == i_idx) begin
                    n_tap = r_data;
                end
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    // Hold the slot word and the read tap
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_tap  <= n_tap;
    end

    assign o_data = r_data;
    assign o_tap  = r_tap;

endmodule

>>> src/indexed_list_insert_delete.sv
// ----------------------------------------------------------------------------
// Indexed list store
// Ordered sequence of up to CAPACITY signed words kept in a row of shift cells.
// ----------------------------------------------------------------------------
//  Channel | Valid       | Stall        | Payload
//  --------+-------------+--------------+----------------------
//  input   | i_in_valid  | o_in_stall   | i_in  (ili_pkg::t_req)
//  output  | o_out_valid | i_out_stall  | o_out (ili_pkg::t_rsp)
//
//  Each transaction steps through capture, cell shift or tap, group gather and
//  group merge into the output register. A new transaction is taken once the
//  previous result has moved to the output register, so it may still be
//  waiting there.
//  Reset clears the count and the controller; cell contents are left as is.
//  A stalled output holds the controller in the merge step until it drains.
// ----------------------------------------------------------------------------
module indexed_list_insert_delete #(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  ili_pkg::t_req i_in,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output ili_pkg::t_rsp o_out
);
    import ili_pkg::*;

    `include "indexed_list_insert_delete_defines.svh"

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int CMP_W  = (CNT_W > 7) ? CNT_W : 7;
    localparam int NGROUP = (CAPACITY + GRP - 1) / GRP;

    t_state                r_state;
    t_state                n_state;
    t_req                  r_req;
    logic [CNT_W-1:0]      r_count;
    logic                  r_found;
    logic                  r_accepted;
    logic                  r_is_read;
    logic [DATA_WIDTH-1:0] r_grp [NGROUP];
    t_rsp                  r_out;
    logic                  r_out_valid;

    logic                  w_accept;
    logic                  w_out_free;
    logic                  w_load_out;
    t_cell_op              w_cell_op;
    logic [CMP_W-1:0]      w_idx;
    logic [CMP_W-1:0]      w_cnt;
    logic [CMP_W-1:0]      w_ins_pos;
    logic [CMP_W-1:0]      w_cell_idx;
    logic                  w_is_ins;
    logic                  w_is_del;
    logic                  w_is_read;
    logic                  w_hit;
    logic                  w_ok_ins;
    logic                  w_ok_del;
    logic signed [63:0]    w_value_wide;
    logic [DATA_WIDTH-1:0] w_wdata;
    logic [DATA_WIDTH-1:0] w_data [CAPACITY];
    logic [DATA_WIDTH-1:0] w_tap  [NGROUP*GRP];
    logic [DATA_WIDTH-1:0] w_grp_or [NGROUP];
    logic [DATA_WIDTH-1:0] w_merged;
    logic signed [DATA_WIDTH-1:0] w_sdata;
    logic signed [63:0]    w_rd_wide;
    t_rsp                  w_rsp;

    // Handshake terms
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;

    // Decode the captured request against the current count
    assign w_idx = CMP_W'(r_req.index);
    assign w_cnt = CMP_W'(r_count);

    always_comb begin
        w_is_ins  = 1'b0;
        w_is_del  = 1'b0;
        w_is_read = 1'b0;
        w_ins_pos = '0;
        case (r_req.req_type)
            REQ_READ: begin
                w_is_read = 1'b1;
            end
            REQ_INS_HEAD: begin
                w_is_ins  = 1'b1;
                w_ins_pos = '0;
            end
            REQ_INS_TAIL: begin
                w_is_ins  = 1'b1;
                w_ins_pos = w_cnt;
            end
            REQ_INS_AT: begin
                w_is_ins  = 1'b1;
                w_ins_pos = w_idx;
            end
            REQ_DELETE: begin
                w_is_del = 1'b1;
            end
            default: begin
                w_is_read = 1'b0;
            end
        endcase
    end

    assign w_hit    = w_is_read && (w_idx < w_cnt);
    assign w_ok_ins = w_is_ins && (w_ins_pos <= w_cnt) && (r_count < CNT_W'(CAPACITY));
    assign w_ok_del = w_is_del && (w_idx < w_cnt);
    assign w_cell_idx = w_is_ins ? w_ins_pos : w_idx;

    // Narrow the insert value to the stored word width
    assign w_value_wide = 64'(r_req.value);
    assign w_wdata      = w_value_wide[DATA_WIDTH-1:0];

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_SHIFT;
                end
            end
            ST_SHIFT: begin
                n_state = ST_GATHER;
            end
            ST_GATHER: begin
                n_state = ST_MERGE;
            end
            ST_MERGE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Controller outputs
    always_comb begin
        o_in_stall = 1'b1;
        w_cell_op  = CELL_HOLD;
        w_load_out = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
            end
            ST_SHIFT: begin
                if (w_ok_ins) begin
                    w_cell_op = CELL_INSERT;
                end else if (w_ok_del) begin
                    w_cell_op = CELL_DELETE;
                end else if (w_is_read) begin
                    w_cell_op = CELL_READ;
                end
            end
            ST_MERGE: begin
                w_load_out = w_out_free;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    // Row of cells, each shifting toward or away from its neighbors
    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        logic [DATA_WIDTH-1:0] w_left;
        logic [DATA_WIDTH-1:0] w_right;

        if (k == 0) begin : g_first
            assign w_left = w_data[k];
        end else begin : g_mid_l
            assign w_left = w_data[k-1];
        end

        if (k == CAPACITY - 1) begin : g_last
            assign w_right = w_data[k];
        end else begin : g_mid_r
            assign w_right = w_data[k+1];
        end

        ili_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .CMP_W      (CMP_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_op    (w_cell_op),
            .i_pos   (CMP_W'(k)),
            .i_idx   (w_cell_idx),
            .i_wdata (w_wdata),
            .i_left  (w_left),
            .i_right (w_right),
            .o_data  (w_data[k]),
            .o_tap   (w_tap[k])
        );
    end

    // Pad the tap row to whole groups
    for (genvar k = CAPACITY; k < NGROUP * GRP; k++) begin : g_pad
        assign w_tap[k] = '0;
    end

    // Merge taps within each group
    for (genvar g = 0; g < NGROUP; g++) begin : g_grp
        always_comb begin
            w_grp_or[g] = '0;
            for (int j = 0; j < GRP; j++) begin
                w_grp_or[g] = w_grp_or[g] | w_tap[g*GRP+j];
            end
        end
    end

    // Merge the group results
    always_comb begin
        w_merged = '0;
        for (int g = 0; g < NGROUP; g++) begin
            w_merged = w_merged | r_grp[g];
        end
    end

    // Build the response
    assign w_sdata   = w_merged;
    assign w_rd_wide = 64'(w_sdata);

    always_comb begin
        w_rsp.found      = r_found;
        w_rsp.accepted   = r_accepted;
        w_rsp.count      = 7'(r_count);
        w_rsp.read_value = '0;
        if (r_is_read) begin
            w_rsp.read_value = r_found ? w_rd_wide[31:0] : '1;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_SHIFT) begin
                if (w_ok_ins) begin
                    r_count <= r_count + 1'b1;
                end else if (w_ok_del) begin
                    r_count <= r_count - 1'b1;
                end
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req <= i_in;
        end
        if (r_state == ST_SHIFT) begin
            r_found    <= w_hit;
            r_accepted <= w_ok_ins || w_ok_del;
            r_is_read  <= w_is_read;
        end
        if (r_state == ST_GATHER) begin
            for (int g = 0; g < NGROUP; g++) begin
                r_grp[g] <= w_grp_or[g];
            end
        end
        if (w_load_out) begin
            r_out <= w_rsp;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Checks
    `ILI_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CNT_W'(CAPACITY),
        "count exceeds capacity")
    `ILI_ASSERT_NEXT(a_accept_shift, w_accept, r_state == ST_SHIFT,
        "accepted transaction did not start a shift")
    `ILI_ASSERT_NEXT(a_count_quiet, r_state != ST_SHIFT, $stable(r_count),
        "count changed outside the shift step")
    `ILI_ASSERT_NEXT(a_insert_count, (r_state == ST_SHIFT) && w_ok_ins,
        r_count == $past(r_count) + 1'b1, "insert did not advance count")

endmodule
